FILE: design/epd_pkg.sv
// package with shared types and codes of the escaped packet deframer
`timescale 1ns / 1ps

package epd_pkg;

   localparam int BODY_LEN = 20;

   localparam logic [1:0] STATUS_GOOD      = 2'd0;
   localparam logic [1:0] STATUS_BAD_START = 2'd1;
   localparam logic [1:0] STATUS_BAD_END   = 2'd2;

   localparam logic [1:0] CSR_START_CODE  = 2'd0;
   localparam logic [1:0] CSR_END_CODE    = 2'd1;
   localparam logic [1:0] CSR_ESCAPE_CODE = 2'd2;

   localparam logic [7:0] START_CODE_RESET  = 8'h02;
   localparam logic [7:0] END_CODE_RESET    = 8'h03;
   localparam logic [7:0] ESCAPE_CODE_RESET = 8'h10;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] packet_id;
      logic [31:0] client_id;
      logic [15:0] op_code;
      logic [15:0] pin_number;
      logic [15:0] pin_mode;
      logic [31:0] data_word;
      logic [15:0] check_value;
      logic        check_ok;
   } result_type;

   typedef struct packed {
      logic [7:0] start_code;
      logic [7:0] end_code;
      logic [7:0] escape_code;
   } codes_type;

endpackage

FILE: design/escaped_packet_deframer_top.sv
// top level of the escaped packet deframer
//
// bytes from the link arrive on the req_ channel, one byte per item, and
// decoded frames leave on the rsp_ channel, one item per frame or per byte
// seen outside a frame that is not the start code (bad start status)
// an item is taken at a clock edge where valid is high and stall is low
// the input byte is registered first; the frame logic then works on it and
// a result goes into the result register; a result is visible once it is
// loaded there and can be taken at the next edge
// throughput is one byte per cycle while req_stall is low, set by the
// combinational frame update between the input register and the result register
// when rsp_stall holds a result, bytes that make no result keep flowing;
// a byte that would make a result waits in the input register and req_stall
// rises until the result register frees; the user writes start, end and
// escape codes on the csr_ port (index 0, 1, 2) only while no item is in
// flight, which the block does not enforce; reset sets them to 0x02, 0x03,
// and 0x10, clears both registers and puts the deframer in start code hunt
`timescale 1ns / 1ps

module escaped_packet_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_packet_id,
   output logic [31:0] rsp_client_id,
   output logic [15:0] rsp_op_code,
   output logic [15:0] rsp_pin_number,
   output logic [15:0] rsp_pin_mode,
   output logic [31:0] rsp_data_word,
   output logic [15:0] rsp_check_value,
   output logic        rsp_check_ok,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import epd_pkg::*;

   codes_type  codes_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       emit;
   logic       step;
   logic       out_free;
   result_type frame_result;
   result_type rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff.start_code  <= START_CODE_RESET;
         codes_ff.end_code    <= END_CODE_RESET;
         codes_ff.escape_code <= ESCAPE_CODE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_CODE:  codes_ff.start_code  <= csr_wdata;
            CSR_END_CODE:    codes_ff.end_code    <= csr_wdata;
            CSR_ESCAPE_CODE: codes_ff.escape_code <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign step      = in_valid_ff && (!emit || out_free);
   assign req_stall = in_valid_ff && !step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_in_byte;
      end
   end

   epd_deframe u_deframe (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .in_byte (in_byte_ff),
      .codes   (codes_ff),
      .emit    (emit),
      .result  (frame_result)
   );

   epd_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step && emit),
      .load_data (frame_result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .free      (out_free)
   );

   assign rsp_status      = rsp_data.status;
   assign rsp_packet_id   = rsp_data.packet_id;
   assign rsp_client_id   = rsp_data.client_id;
   assign rsp_op_code     = rsp_data.op_code;
   assign rsp_pin_number  = rsp_data.pin_number;
   assign rsp_pin_mode    = rsp_data.pin_mode;
   assign rsp_data_word   = rsp_data.data_word;
   assign rsp_check_value = rsp_data.check_value;
   assign rsp_check_ok    = rsp_data.check_ok;

   assert property (@(posedge clock) disable iff (reset)
      step && emit |=> rsp_valid)
      else $error("result item lost on its way to the result register");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_GOOD || rsp_status == STATUS_BAD_START ||
                    rsp_status == STATUS_BAD_END)
      else $error("reserved status code on the result channel");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_BAD_START |->
         rsp_packet_id == '0 && rsp_check_value == '0 && !rsp_check_ok)
      else $error("bad start item carries frame fields");

endmodule

FILE: design/epd_deframe.sv
// frame state machine, body byte store and field decode
`timescale 1ns / 1ps

module epd_deframe (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          in_byte,
   input  epd_pkg::codes_type  codes,
   output logic                emit,
   output epd_pkg::result_type result
);
   import epd_pkg::*;

   localparam logic [1:0] PH_HUNT = 2'd0;
   localparam logic [1:0] PH_BODY = 2'd1;
   localparam logic [1:0] PH_END  = 2'd2;

   localparam logic [4:0] LAST_COUNT = 5'(BODY_LEN);

   logic [1:0] phase_ff, phase_in;
   logic [4:0] count_ff, count_in;
   logic       esc_ff, esc_in;
   logic       store;
   logic [7:0] body_ff [BODY_LEN];

   logic [31:0] id_w, cid_w, data_w;
   logic [15:0] op_w, pin_w, mode_w, chk_w, pack_w;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      esc_in   = esc_ff;
      store    = 1'b0;
      emit     = 1'b0;
      unique case (phase_ff)
         PH_BODY: begin
            if (!esc_ff && in_byte == codes.escape_code) begin
               esc_in = 1'b1;
            end else begin
               esc_in   = 1'b0;
               store    = 1'b1;
               count_in = count_ff + 5'd1;
               if (count_in >= LAST_COUNT) begin
                  phase_in = PH_END;
               end
            end
         end
         PH_END: begin
            emit     = 1'b1;
            phase_in = PH_HUNT;
            count_in = '0;
            esc_in   = 1'b0;
         end
         default: begin
            if (in_byte == codes.start_code) begin
               phase_in = PH_BODY;
               count_in = '0;
               esc_in   = 1'b0;
            end else begin
               emit     = 1'b1;
               phase_in = PH_HUNT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
         esc_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         esc_ff   <= esc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && store && count_ff < LAST_COUNT) begin
         body_ff[count_ff] <= in_byte;
      end
   end

   assign id_w   = {body_ff[3], body_ff[2], body_ff[1], body_ff[0]};
   assign cid_w  = {body_ff[7], body_ff[6], body_ff[5], body_ff[4]};
   assign op_w   = {body_ff[9], body_ff[8]};
   assign pin_w  = {body_ff[11], body_ff[10]};
   assign mode_w = {body_ff[13], body_ff[12]};
   assign data_w = {body_ff[17], body_ff[16], body_ff[15], body_ff[14]};
   assign chk_w  = {body_ff[19], body_ff[18]};
   assign pack_w = {id_w[3:0], cid_w[3:0], pin_w[3:0], mode_w[3:0]};

   always_comb begin
      result = '0;
      if (phase_ff == PH_END) begin
         result.status      = (in_byte == codes.end_code) ? STATUS_GOOD : STATUS_BAD_END;
         result.packet_id   = id_w;
         result.client_id   = cid_w;
         result.op_code     = op_w;
         result.pin_number  = pin_w;
         result.pin_mode    = mode_w;
         result.data_word   = data_w;
         result.check_value = chk_w;
         result.check_ok    = (chk_w == pack_w);
      end else begin
         result.status = STATUS_BAD_START;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_COUNT)
      else $error("body byte count past frame length");

   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_END |-> count_ff == LAST_COUNT)
      else $error("end phase without a full body");

   assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> phase_ff == PH_BODY)
      else $error("escape pending outside the body");

endmodule

FILE: design/epd_rsp_reg.sv
// result register that holds one item for the result channel
`timescale 1ns / 1ps

module epd_rsp_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  epd_pkg::result_type load_data,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output epd_pkg::result_type rsp_data,
   output logic                free
);
   import epd_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   assign free      = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

FILE: tb/escaped_packet_deframer_top_tb.sv
// self-checking testbench for the escaped packet deframer top level
`timescale 1ns / 1ps

module escaped_packet_deframer_top_tb;

   import epd_pkg::*;

   typedef enum logic [1:0] {SEEK_START, IN_BODY, AT_END} frame_phase_type;

   localparam int TRAIL_CYCLES = 6;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int SETTINGS_RUN = 8;
   localparam int BYTES_PER_SETTING = 135;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_packet_id;
   logic [31:0] rsp_client_id;
   logic [15:0] rsp_op_code;
   logic [15:0] rsp_pin_number;
   logic [15:0] rsp_pin_mode;
   logic [31:0] rsp_data_word;
   logic [15:0] rsp_check_value;
   logic        rsp_check_ok;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_START_CODE;
   logic [7:0]  csr_wdata = 8'h00;

   // deframer prediction state
   codes_type       live_codes;
   frame_phase_type frame_phase;
   int              body_count;
   logic            escape_armed;
   logic [7:0]      body_bytes [BODY_LEN];
   result_type      awaited_results [$];

   // stimulus state
   logic [7:0]   frame_body [BODY_LEN];
   int           send_idle_pct = 0;
   int           stall_pct = 0;
   int           errors = 0;
   int           bytes_sent = 0;
   int           good_seen = 0;
   int           bad_end_seen = 0;
   int           bad_start_seen = 0;
   result_type   want_result;

   escaped_packet_deframer_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_packet_id(rsp_packet_id),
      .rsp_client_id(rsp_client_id),
      .rsp_op_code(rsp_op_code),
      .rsp_pin_number(rsp_pin_number),
      .rsp_pin_mode(rsp_pin_mode),
      .rsp_data_word(rsp_data_word),
      .rsp_check_value(rsp_check_value),
      .rsp_check_ok(rsp_check_ok),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("escaped_packet_deframer_top test failed");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   function automatic result_type frame_result(input logic [1:0] status);
      result_type r;
      logic [15:0] nibble_pack;
      r.status      = status;
      r.packet_id   = {body_bytes[3], body_bytes[2], body_bytes[1], body_bytes[0]};
      r.client_id   = {body_bytes[7], body_bytes[6], body_bytes[5], body_bytes[4]};
      r.op_code     = {body_bytes[9], body_bytes[8]};
      r.pin_number  = {body_bytes[11], body_bytes[10]};
      r.pin_mode    = {body_bytes[13], body_bytes[12]};
      r.data_word   = {body_bytes[17], body_bytes[16], body_bytes[15], body_bytes[14]};
      r.check_value = {body_bytes[19], body_bytes[18]};
      nibble_pack   = {r.packet_id[3:0], r.client_id[3:0], r.pin_number[3:0],
                       r.pin_mode[3:0]};
      r.check_ok    = (r.check_value == nibble_pack);
      return r;
   endfunction

   function automatic void deframe_byte(input logic [7:0] b);
      result_type r;
      case (frame_phase)
         IN_BODY: begin
            if (!escape_armed && b == live_codes.escape_code) begin
               escape_armed = 1'b1;
            end else begin
               escape_armed = 1'b0;
               body_bytes[body_count] = b;
               body_count++;
               if (body_count == BODY_LEN) frame_phase = AT_END;
            end
         end
         AT_END: begin
            awaited_results.push_back(frame_result(
               (b == live_codes.end_code) ? STATUS_GOOD : STATUS_BAD_END));
            frame_phase  = SEEK_START;
            body_count   = 0;
            escape_armed = 1'b0;
         end
         default: begin
            if (b == live_codes.start_code) begin
               frame_phase  = IN_BODY;
               body_count   = 0;
               escape_armed = 1'b0;
            end else begin
               frame_phase = SEEK_START;
               r = '0;
               r.status = STATUS_BAD_START;
               awaited_results.push_back(r);
            end
         end
      endcase
   endfunction

   function automatic void check_field(input string fname, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual status %h",
                     $time, rsp_status);
         end else begin
            want_result = awaited_results.pop_front();
            check_field("status", 32'(want_result.status), 32'(rsp_status));
            check_field("packet_id", want_result.packet_id, rsp_packet_id);
            check_field("client_id", want_result.client_id, rsp_client_id);
            check_field("op_code", 32'(want_result.op_code), 32'(rsp_op_code));
            check_field("pin_number", 32'(want_result.pin_number), 32'(rsp_pin_number));
            check_field("pin_mode", 32'(want_result.pin_mode), 32'(rsp_pin_mode));
            check_field("data_word", want_result.data_word, rsp_data_word);
            check_field("check_value", 32'(want_result.check_value),
                        32'(rsp_check_value));
            check_field("check_ok", 32'(want_result.check_ok), 32'(rsp_check_ok));
            case (want_result.status)
               STATUS_GOOD:    good_seen++;
               STATUS_BAD_END: bad_end_seen++;
               default:        bad_start_seen++;
            endcase
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      deframe_byte(b);
      bytes_sent++;
   endtask

   // hold the sender until every awaited result is in, then let the pipe empty
   task automatic wait_drained();
      int cycles;
      cycles = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0 && cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      if (awaited_results.size() != 0) begin
         errors++;
         $display("%0t: results missing, expected %0d more, actual 0",
                  $time, awaited_results.size());
         awaited_results.delete();
      end
      repeat (TRAIL_CYCLES) @(posedge clock);
   endtask

   task automatic set_codes(input logic [7:0] start_c, input logic [7:0] end_c,
                            input logic [7:0] escape_c);
      csr_we    <= 1'b1;
      csr_index <= CSR_START_CODE;
      csr_wdata <= start_c;
      @(posedge clock);
      csr_index <= CSR_END_CODE;
      csr_wdata <= end_c;
      @(posedge clock);
      csr_index <= CSR_ESCAPE_CODE;
      csr_wdata <= escape_c;
      @(posedge clock);
      csr_we <= 1'b0;
      live_codes.start_code  = start_c;
      live_codes.end_code    = end_c;
      live_codes.escape_code = escape_c;
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return live_codes.start_code;
         1: return live_codes.end_code;
         2: return live_codes.escape_code;
         3: return 8'h00;
         4: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void seal_check_value();
      frame_body[18] = {frame_body[10][3:0], frame_body[12][3:0]};
      frame_body[19] = {frame_body[0][3:0], frame_body[4][3:0]};
   endfunction

   // start code, body bytes with optional stuffing, then the closing byte if the body is whole
   task automatic send_frame(input logic [7:0] tail, input int body_len,
                             input int extra_escape_pct, input bit stuffing);
      send_byte(live_codes.start_code);
      for (int i = 0; i < body_len; i++) begin
         if (stuffing && (frame_body[i] == live_codes.escape_code ||
                          $urandom_range(0, 99) < extra_escape_pct))
            send_byte(live_codes.escape_code);
         send_byte(frame_body[i]);
      end
      if (body_len == BODY_LEN) send_byte(tail);
   endtask

   task automatic set_idling(input int pattern);
      case (pattern)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 88; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 88; end
         default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
   endtask

   task automatic test_directed_frame();
      set_idling(0);
      // stray bytes while hunting
      send_byte(8'h00);
      send_byte(8'hFF);
      // body holds start and end codes as plain data, an escaped escape code,
      // and the frame is closed by a raw escape code instead of the end code
      frame_body[0] = 8'h00;
      frame_body[1] = 8'hFF;
      frame_body[2] = START_CODE_RESET;
      frame_body[3] = END_CODE_RESET;
      frame_body[4] = ESCAPE_CODE_RESET;
      frame_body[5] = 8'h80;
      frame_body[6] = 8'h7F;
      frame_body[7] = 8'h01;
      for (int i = 8; i < BODY_LEN; i++) frame_body[i] = 8'($urandom_range(0, 255));
      seal_check_value();
      send_frame(ESCAPE_CODE_RESET, BODY_LEN, 0, 1'b1);
      wait_drained();
   endtask

   task automatic run_traffic(input int n_bytes);
      int stop_at;
      int body_len;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) begin
         case ($urandom_range(0, 19))
            0, 1, 2: begin
               // noise on the line
               repeat ($urandom_range(1, 4)) send_byte(pick_byte());
            end
            3, 4: begin
               // cut-off body, the next bytes run into it
               for (int i = 0; i < BODY_LEN; i++) frame_body[i] = pick_byte();
               body_len = $urandom_range(1, BODY_LEN - 1);
               send_frame(live_codes.end_code, body_len, 10, 1'b1);
            end
            5: begin
               // escape codes left unstuffed
               for (int i = 0; i < BODY_LEN; i++) frame_body[i] = pick_byte();
               send_frame(pick_byte(), BODY_LEN, 0, 1'b0);
            end
            default: begin
               for (int i = 0; i < BODY_LEN; i++) frame_body[i] = pick_byte();
               if ($urandom_range(0, 1)) seal_check_value();
               send_frame(($urandom_range(0, 7) == 0) ? pick_byte() : live_codes.end_code,
                          BODY_LEN, 15, 1'b1);
            end
         endcase
      end
      wait_drained();
   endtask

   task automatic test_code_settings();
      for (int s = 0; s < SETTINGS_RUN; s++) begin
         case (s)
            0: set_codes(START_CODE_RESET, END_CODE_RESET, ESCAPE_CODE_RESET);
            1: set_codes(8'h00, 8'hFF, 8'h80);
            2: set_codes(8'hFF, 8'h00, 8'hFF);
            3: set_codes(8'h55, 8'h55, 8'h55);
            6: set_codes(8'h7E, 8'h7E, 8'h7D);
            default: set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)));
         endcase
         set_idling(s % 4);
         run_traffic(BYTES_PER_SETTING);
      end
      set_idling(0);
   endtask

   initial begin
      live_codes.start_code  = START_CODE_RESET;
      live_codes.end_code    = END_CODE_RESET;
      live_codes.escape_code = ESCAPE_CODE_RESET;
      frame_phase  = SEEK_START;
      body_count   = 0;
      escape_armed = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_frame();
      test_code_settings();
      $display("covered %0d input bytes over %0d code settings and four idle patterns",
               bytes_sent, SETTINGS_RUN + 1);
      $display("results checked: %0d good frames, %0d bad end, %0d bad start",
               good_seen, bad_end_seen, bad_start_seen);
      if (errors == 0) begin
         $display("escaped_packet_deframer_top test passed");
      end else begin
         $display("escaped_packet_deframer_top test failed");
      end
      $finish;
   end

endmodule
